FILE: hw/rtl/mcws_pkg.sv
`default_nettype none

package mcws_pkg;

   // Table geometry
   localparam int MAX_APPS  = 32;
   localparam int ADDR_W    = $clog2(MAX_APPS);
   localparam int COUNT_W   = $clog2(MAX_APPS) + 1;

   // Fixed field widths
   localparam int ID_W           = 16;
   localparam int CMD_W          = 8;
   localparam int AGE_W          = 8;
   localparam int CSR_DATA_W     = 8;
   localparam int CSR_INDEX_W    = 1;
   localparam int CLIENT_COUNT_W = 5;

   // Client commands
   localparam logic [CMD_W-1:0] CMD_KICK       = 8'd1;
   localparam logic [CMD_W-1:0] CMD_UNREGISTER = 8'd2;

   // Ages stop counting at this value
   localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

   // Request types
   localparam logic REQ_COMMAND = 1'b0;
   localparam logic REQ_TICK    = 1'b1;

   // Register reset values
   localparam logic [CSR_DATA_W-1:0] REBOOT_LIMIT_RESET  = 8'd5;
   localparam logic [CSR_DATA_W-1:0] TICK_PRESCALE_RESET = 8'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_REBOOT_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PRESCALE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_NOT_FOUND,
      ST_APPLY,
      ST_MOVE,
      ST_AGE,
      ST_DONE
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // capture the request
      logic prescale_step; // advance the prescale counter
      logic scan_start;    // read entry 0, index to 0
      logic scan_step;     // read next entry, index + 1
      logic set_slot;      // remember the matching index
      logic append;        // write a new client at the end
      logic kick_clear;    // clear the age of the slot
      logic read_last;     // read the last entry
      logic move;          // copy the last entry into the slot
      logic age_write;     // age the entry at the index
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_tick;
      logic is_kick;
      logic is_unregister;
      logic table_empty;
      logic table_full;
      logic prescale_zero;
      logic id_match;
      logic scan_last;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_client_watchdog_supervisor.sv
// Throughput: one request at a time; busy falls in the cycle after the strobe, so the next
// request can be taken at the end of that cycle. The sequential walk over the table sets it.
// Reset (synchronous, active high) empties the client list, restores both registers and
// the prescale counter; the receiver cannot stall the result, which stands for one cycle.
`default_nettype none

module multi_client_watchdog_supervisor
   import mcws_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_type,
   input  wire logic [ID_W-1:0]           req_client_id,
   input  wire logic [CMD_W-1:0]          req_command,
   // Result channel
   output logic                           rsp_strobe,
   output logic                           rsp_reboot_request,
   output logic                           rsp_kick_pulse,
   output logic [CLIENT_COUNT_W-1:0]      rsp_client_count,
   // Register write port
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_write_data
);

   // The controller sequences each request through the table: a command scans
   // for its client id one entry per cycle (the table memories have a registered
   // read, so the compare sees the entry addressed in the cycle before), then appends,
   // clears the age or moves the last entry into the freed slot. A tick advances
   // the prescale counter and, when it was zero, walks every entry, writing back
   // the incremented age of one entry while reading the age of the next.
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mcws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the id and age memories, the client count, the
   // prescale counter, both registers and the result fields. The result fields
   // are registers, so they are stable during the strobe cycle.
   mcws_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_type           (req_type),
      .req_client_id      (req_client_id),
      .req_command        (req_command),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_kick_pulse     (rsp_kick_pulse),
      .rsp_client_count   (rsp_client_count)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mcws_ctrl.sv
`default_nettype none

module mcws_ctrl
   import mcws_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd,
   output logic                 busy,
   output logic                 rsp_strobe
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_tick) begin
               cmd.prescale_step = 1'b1;
               if (status.prescale_zero && !status.table_empty) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_AGE;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (status.table_empty) begin
               state_in = ST_NOT_FOUND;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.id_match) begin
               cmd.set_slot = 1'b1;
               state_in     = ST_APPLY;
            end else if (status.scan_last) begin
               state_in = ST_NOT_FOUND;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_NOT_FOUND: begin
            if (status.table_full) begin
               state_in = ST_DONE;
            end else begin
               cmd.append = 1'b1;
               state_in   = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (status.is_kick) begin
               cmd.kick_clear = 1'b1;
               state_in       = ST_DONE;
            end else if (status.is_unregister) begin
               cmd.read_last = 1'b1;
               state_in      = ST_MOVE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_DONE;
         end
         ST_AGE: begin
            cmd.age_write = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mcws_datapath.sv
`default_nettype none

module mcws_datapath
   import mcws_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ctrl_cmd_type              cmd,
   output ctrl_status_type                status,
   input  wire logic                      req_type,
   input  wire logic [ID_W-1:0]           req_client_id,
   input  wire logic [CMD_W-1:0]          req_command,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_write_data,
   output logic                           rsp_reboot_request,
   output logic                           rsp_kick_pulse,
   output logic [CLIENT_COUNT_W-1:0]      rsp_client_count
);

   logic [ID_W-1:0]  id_mem  [MAX_APPS];
   logic [AGE_W-1:0] age_mem [MAX_APPS];

   logic [ID_W-1:0]       rd_id_ff;
   logic [AGE_W-1:0]      rd_age_ff;
   logic                  type_ff;
   logic [ID_W-1:0]       cid_ff;
   logic [CMD_W-1:0]      command_ff;
   logic [ADDR_W-1:0]     idx_ff;
   logic [ADDR_W-1:0]     slot_ff;
   logic [COUNT_W-1:0]    used_ff;
   logic [AGE_W-1:0]      prescale_ff;
   logic [CSR_DATA_W-1:0] reboot_limit_ff;
   logic [CSR_DATA_W-1:0] tick_prescale_ff;
   logic                  reboot_ff;

   logic [COUNT_W-1:0]    idx_next;
   logic [COUNT_W-1:0]    last_entry;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  id_we;
   logic [ADDR_W-1:0]     id_waddr;
   logic [ID_W-1:0]       id_wdata;
   logic                  age_we;
   logic [ADDR_W-1:0]     age_waddr;
   logic [AGE_W-1:0]      age_wdata;
   logic [AGE_W-1:0]      age_inc;
   logic [AGE_W-1:0]      prescale_base;

   assign idx_next   = COUNT_W'(idx_ff) + COUNT_W'(1);
   assign last_entry = used_ff - COUNT_W'(1);
   assign age_inc    = (rd_age_ff == AGE_MAX) ? rd_age_ff : rd_age_ff + AGE_W'(1);

   always_comb begin
      rd_addr = '0;
      if (cmd.scan_step) begin
         rd_addr = ADDR_W'(idx_next);
      end else if (cmd.read_last) begin
         rd_addr = ADDR_W'(last_entry);
      end
   end

   always_comb begin
      id_we     = 1'b0;
      id_waddr  = slot_ff;
      id_wdata  = rd_id_ff;
      age_we    = 1'b0;
      age_waddr = slot_ff;
      age_wdata = rd_age_ff;
      if (cmd.append) begin
         id_we     = 1'b1;
         id_waddr  = ADDR_W'(used_ff);
         id_wdata  = cid_ff;
         age_we    = 1'b1;
         age_waddr = ADDR_W'(used_ff);
         age_wdata = '0;
      end else if (cmd.move) begin
         id_we  = 1'b1;
         age_we = 1'b1;
      end else if (cmd.kick_clear) begin
         age_we    = 1'b1;
         age_wdata = '0;
      end else if (cmd.age_write) begin
         age_we    = 1'b1;
         age_waddr = idx_ff;
         age_wdata = age_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= id_wdata;
      end
      rd_id_ff <= id_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[age_waddr] <= age_wdata;
      end
      rd_age_ff <= age_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff    <= req_type;
         cid_ff     <= req_client_id;
         command_ff <= req_command;
         reboot_ff  <= 1'b0;
      end else if (cmd.age_write && (rd_age_ff > reboot_limit_ff)) begin
         reboot_ff <= 1'b1;
      end
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= ADDR_W'(idx_next);
      end
      if (cmd.set_slot) begin
         slot_ff <= idx_ff;
      end else if (cmd.append) begin
         slot_ff <= ADDR_W'(used_ff);
      end
   end

   assign prescale_base = (prescale_ff == '0) ? tick_prescale_ff : prescale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff          <= '0;
         prescale_ff      <= TICK_PRESCALE_RESET;
         reboot_limit_ff  <= REBOOT_LIMIT_RESET;
         tick_prescale_ff <= TICK_PRESCALE_RESET;
      end else begin
         if (cmd.append) begin
            used_ff <= used_ff + COUNT_W'(1);
         end else if (cmd.move) begin
            used_ff <= last_entry;
         end
         if (cmd.prescale_step) begin
            prescale_ff <= prescale_base - AGE_W'(1);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REBOOT_LIMIT:  reboot_limit_ff  <= csr_write_data;
               CSR_TICK_PRESCALE: tick_prescale_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign status.is_tick       = (type_ff == REQ_TICK);
   assign status.is_kick       = (command_ff == CMD_KICK);
   assign status.is_unregister = (command_ff == CMD_UNREGISTER);
   assign status.table_empty   = (used_ff == '0);
   assign status.table_full    = (used_ff >= COUNT_W'(MAX_APPS - 1));
   assign status.prescale_zero = (prescale_ff == '0);
   assign status.id_match      = (rd_id_ff == cid_ff);
   assign status.scan_last     = (idx_next == used_ff);

   assign rsp_reboot_request = reboot_ff;
   assign rsp_kick_pulse     = type_ff;
   assign rsp_client_count   = CLIENT_COUNT_W'(used_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/mcws_checker.sv
`default_nettype none

module mcws_checker
   import mcws_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      rsp_strobe,
   input wire logic                      rsp_reboot_request,
   input wire logic                      rsp_kick_pulse,
   input wire logic [CLIENT_COUNT_W-1:0] rsp_client_count
);

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   // A result is only given while a request is in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // After the result the block is free again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block still busy after its result");

   // Only a tick can ask for a reboot.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_kick_pulse) |-> !rsp_reboot_request)
      else $error("reboot requested by a client command");

   // The table never holds more than its capacity less one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_client_count) <= 32'(MAX_APPS - 1)))
      else $error("client count beyond table capacity");

endmodule

bind multi_client_watchdog_supervisor mcws_checker u_mcws_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_strobe         (rsp_strobe),
   .rsp_reboot_request (rsp_reboot_request),
   .rsp_kick_pulse     (rsp_kick_pulse),
   .rsp_client_count   (rsp_client_count)
);

`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
   import mcws_pkg::*;

   // Give up long after the slowest legal run would have finished.
   localparam int CYCLE_LIMIT  = 400000;
   // Time waited after the last request, so this covers any stragglers.
   localparam int DRAIN_CYCLES = 40;
   localparam int ID_POOL_SIZE = 40;

   // One request as seen on the request channel.
   typedef struct packed {
      logic             kind;
      logic [ID_W-1:0]  client_id;
      logic [CMD_W-1:0] command;
   } watchdog_request_type;

   // One result as seen on the result channel.
   typedef struct packed {
      logic                      reboot_request;
      logic                      kick_pulse;
      logic [CLIENT_COUNT_W-1:0] client_count;
   } watchdog_outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_type = REQ_COMMAND;
   logic [ID_W-1:0]           req_client_id = '0;
   logic [CMD_W-1:0]          req_command = '0;
   logic                      rsp_strobe;
   logic                      rsp_reboot_request;
   logic                      rsp_kick_pulse;
   logic [CLIENT_COUNT_W-1:0] rsp_client_count;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   // Requests waiting to be driven, and the results predicted for accepted requests.
   watchdog_request_type request_backlog[$];
   watchdog_outcome_type outstanding_outcomes[$];

   // The testbench's own view of the supervisor's state and registers.
   logic [ID_W-1:0]       client_ids[MAX_APPS];
   logic [AGE_W-1:0]      client_ages[MAX_APPS];
   int                    clients_used;
   logic [CSR_DATA_W-1:0] prescale_counter;
   logic [CSR_DATA_W-1:0] reboot_limit;
   logic [CSR_DATA_W-1:0] prescale_reload;

   logic [ID_W-1:0]      id_pool[ID_POOL_SIZE];
   bit                   gaps_enabled = 1'b1;
   int                   failure_count = 0;
   int                   cycle_count = 0;
   int                   idle_gap = 0;
   watchdog_request_type current_request;

   multi_client_watchdog_supervisor i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_client_id      (req_client_id),
      .req_command        (req_command),
      .rsp_strobe         (rsp_strobe),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_kick_pulse     (rsp_kick_pulse),
      .rsp_client_count   (rsp_client_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // Works out what the supervisor must answer to one accepted request and advances the
   // predicted state accordingly.
   function automatic watchdog_outcome_type supervise_request(watchdog_request_type rq);
      watchdog_outcome_type outcome;
      int                   slot;
      int                   last;
      outcome = '0;
      if (rq.kind == REQ_TICK) begin
         outcome.kick_pulse = 1'b1;
         // Ageing only happens on the tick that finds the prescale counter at zero, and the
         // reboot decision looks at the ages before they are incremented.
         if (prescale_counter == 0) begin
            prescale_counter = prescale_reload;
            for (int i = 0; i < clients_used; i++) begin
               if (client_ages[i] > reboot_limit)
                  outcome.reboot_request = 1'b1;
               if (client_ages[i] != AGE_MAX)
                  client_ages[i] = client_ages[i] + 1'b1;
            end
         end
         prescale_counter = prescale_counter - 1'b1;
      end else begin
         slot = clients_used;
         for (int i = clients_used - 1; i >= 0; i--) begin
            if (client_ids[i] == rq.client_id)
               slot = i;
         end
         // A stranger arriving at a full table is dropped without any effect.
         if (slot == clients_used && clients_used < MAX_APPS - 1) begin
            client_ids[slot]  = rq.client_id;
            client_ages[slot] = '0;
            clients_used++;
         end
         if (slot < clients_used) begin
            if (rq.command == CMD_KICK)
               client_ages[slot] = '0;
            if (rq.command == CMD_UNREGISTER) begin
               last              = clients_used - 1;
               client_ids[slot]  = client_ids[last];
               client_ages[slot] = client_ages[last];
               clients_used      = last;
            end
         end
      end
      outcome.client_count = clients_used[CLIENT_COUNT_W-1:0];
      return outcome;
   endfunction

   // Mostly back-to-back requests, some short pauses and the odd long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_enabled || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   task automatic flag_failure(string what);
      failure_count++;
      if (failure_count <= 10)
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic queue_request(logic kind, logic [ID_W-1:0] id, logic [CMD_W-1:0] cmd);
      watchdog_request_type rq;
      rq.kind      = kind;
      rq.client_id = id;
      rq.command   = cmd;
      request_backlog.push_back(rq);
   endtask

   // Ticks carry random id and command values, which the supervisor must ignore.
   task automatic queue_ticks(int count);
      for (int i = 0; i < count; i++)
         queue_request(REQ_TICK, ID_W'($urandom_range(0, 16'hFFFF)),
                       CMD_W'($urandom_range(0, 255)));
   endtask

   // A random mix of ticks and client commands. Most commands come from a pool of ids that
   // is a little larger than the table, so clients are found again, the table fills up and
   // strangers are turned away; now and then a completely random id is thrown in.
   task automatic queue_random_mix(int count, int unregister_pct, int tick_pct);
      int               roll;
      logic [ID_W-1:0]  id;
      logic [CMD_W-1:0] cmd;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            queue_ticks(1);
         end else begin
            if ($urandom_range(0, 9) == 0)
               id = ID_W'($urandom_range(0, 16'hFFFF));
            else
               id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
            roll = $urandom_range(0, 99);
            if (roll < unregister_pct)
               cmd = CMD_UNREGISTER;
            else if (roll < unregister_pct + 40)
               cmd = CMD_KICK;
            else
               cmd = CMD_W'($urandom_range(0, 255));
            queue_request(REQ_COMMAND, id, cmd);
         end
      end
   endtask

   // Registers may only change while the supervisor is idle: nothing left to drive, nothing
   // in flight and busy low.
   task automatic drain_requests();
      while (request_backlog.size() != 0 || start || outstanding_outcomes.size() != 0
             || busy !== 1'b0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_REBOOT_LIMIT)
         reboot_limit = value;
      else
         prescale_reload = value;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] limit, logic [CSR_DATA_W-1:0] reload);
      drain_requests();
      write_register(CSR_REBOOT_LIMIT, limit);
      write_register(CSR_TICK_PRESCALE, reload);
   endtask

   // Request driver. A request is taken at an edge where start is high and busy is low; the
   // prediction is made at that very edge, so it sees the registers exactly as the block does.
   // start stays high across back-to-back requests rather than dropping for a cycle.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         idle_gap = 0;
      end else begin
         if (start && busy === 1'b0) begin
            outstanding_outcomes.push_back(supervise_request(current_request));
            idle_gap = pick_gap();
         end
         if (!start || busy === 1'b0) begin
            if (idle_gap > 0) begin
               idle_gap--;
               start <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               current_request = request_backlog.pop_front();
               req_type      <= current_request.kind;
               req_client_id <= current_request.client_id;
               req_command   <= current_request.command;
               start         <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every strobe must match the oldest prediction, field by field.
   always @(posedge clock) begin : result_monitor
      watchdog_outcome_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (outstanding_outcomes.size() == 0) begin
            flag_failure($sformatf("unexpected result: reboot %0b kick %0b count %0d",
                                   rsp_reboot_request, rsp_kick_pulse, rsp_client_count));
         end else begin
            want = outstanding_outcomes.pop_front();
            if (rsp_reboot_request !== want.reboot_request)
               flag_failure($sformatf("reboot_request expected %0b, got %0b",
                                      want.reboot_request, rsp_reboot_request));
            if (rsp_kick_pulse !== want.kick_pulse)
               flag_failure($sformatf("kick_pulse expected %0b, got %0b",
                                      want.kick_pulse, rsp_kick_pulse));
            if (rsp_client_count !== want.client_count)
               flag_failure($sformatf("client_count expected %0d, got %0d",
                                      want.client_count, rsp_client_count));
         end
      end
   end

   // Watchdog for the testbench itself.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      // Predicted state after reset: empty table, registers and prescale counter at their
      // reset values.
      clients_used     = 0;
      reboot_limit     = REBOOT_LIMIT_RESET;
      prescale_reload  = TICK_PRESCALE_RESET;
      prescale_counter = TICK_PRESCALE_RESET;
      for (int i = 0; i < MAX_APPS; i++) begin
         client_ids[i]  = '0;
         client_ages[i] = '0;
      end
      for (int i = 0; i < ID_POOL_SIZE; i++)
         id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with the reset register values: extreme ids and commands, a kick
      // for a new client, and an unregister for a new client, which is appended and removed
      // again at once. Three ticks run the prescale counter down to its first reload.
      queue_request(REQ_COMMAND, 16'h0000, 8'h00);
      queue_request(REQ_COMMAND, 16'hFFFF, 8'hFF);
      queue_request(REQ_COMMAND, 16'h1234, CMD_KICK);
      queue_request(REQ_COMMAND, 16'hABCD, CMD_UNREGISTER);
      queue_ticks(3);
      // Removing the first client pulls the last entry into its slot.
      queue_request(REQ_COMMAND, 16'h0000, CMD_UNREGISTER);
      queue_request(REQ_COMMAND, 16'hFFFF, CMD_KICK);
      queue_request(REQ_COMMAND, 16'h1234, 8'h80);

      // A limit of zero with ageing on every tick: any client that has aged at all forces
      // a reboot on the next ageing pass. The new prescale value only applies at a reload.
      configure(8'd0, 8'd1);
      queue_ticks(2);
      queue_request(REQ_COMMAND, 16'hFFFF, CMD_KICK);
      queue_request(REQ_COMMAND, 16'h5A5A, 8'h03);
      queue_ticks(1);
      queue_request(REQ_COMMAND, 16'h1234, CMD_UNREGISTER);
      queue_ticks(1);

      // Long run of ticks with ageing every tick, so that ages saturate and only then exceed
      // the largest limit below saturation. Without pauses, to keep the block fully loaded.
      configure(8'd254, 8'd1);
      gaps_enabled = 1'b0;
      queue_ticks(262);
      // At the top limit no age can exceed it, so no reboot may appear.
      configure(8'd255, 8'd1);
      queue_ticks(6);
      gaps_enabled = 1'b1;

      // Random phases across a spread of register settings. Phases with few unregisters let
      // the table fill up so that strangers are turned away; one phase runs without pauses.
      configure(8'd3, 8'd1);
      queue_random_mix(85, 5, 25);
      configure(8'd254, 8'd255);
      queue_random_mix(85, 25, 30);
      configure(8'd0, 8'd0);
      gaps_enabled = 1'b0;
      queue_random_mix(85, 15, 30);
      configure(8'd10, 8'd2);
      gaps_enabled = 1'b1;
      queue_random_mix(85, 4, 35);
      configure(8'd255, 8'd1);
      queue_random_mix(85, 30, 30);
      configure(8'd1, 8'd3);
      queue_random_mix(85, 10, 40);

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outstanding_outcomes.size() != 0)
         flag_failure($sformatf("%0d results never arrived", outstanding_outcomes.size()));
      if (failure_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/mcws_pkg.sv
hw/rtl/mcws_ctrl.sv
hw/rtl/mcws_datapath.sv
hw/rtl/multi_client_watchdog_supervisor.sv
hw/rtl/mcws_checker.sv
dv/tb_top.sv
